// ----- src/kctc_pkg.sv -----
// Shared constants, codes and address helpers for the keycode translator.
`default_nettype none

package kctc_pkg;

    // Keymap sizing
    localparam int MAP_BYTES  = 4096;
    localparam int MAP_AW     = $clog2(MAP_BYTES);
    localparam int MAX_RANGES = 8;
    localparam int RANGE_AW   = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int RANGE_CW   = $clog2(MAX_RANGES + 1);
    localparam int MAX_CHARS  = 16;
    localparam int CHAR_CW    = $clog2(MAX_CHARS + 1);

    // Control masks the character down to the C0 range
    localparam logic [7:0] CTRL_MASK = 8'h1f;

    // Request codes
    localparam logic [1:0] REQ_WR_BYTE   = 2'd0;
    localparam logic [1:0] REQ_WR_RANGE  = 2'd1;
    localparam logic [1:0] REQ_TRANSLATE = 2'd2;

    // Range kinds
    localparam logic [1:0] KIND_TRAP   = 2'd0;
    localparam logic [1:0] KIND_STRING = 2'd3;

    // Configuration register indexes
    localparam logic CFG_MAP_VALID   = 1'b0;
    localparam logic CFG_RANGE_COUNT = 1'b1;

    typedef logic [MAP_AW-1:0] t_maddr;

    // One range descriptor
    typedef struct packed {
        logic [7:0]  low;
        logic [7:0]  high;
        logic [1:0]  kind;
        logic [11:0] base;
    } t_range;

    // Wrap a 16-bit byte address onto the map
    function automatic t_maddr fit_addr(input logic [15:0] v);
        logic [31:0] w;
        w = {16'd0, v};
        return w[MAP_AW-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/kctc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module kctc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/keycode_to_char_translator.sv -----
// Top level: keymap storage, range search and character sequencer.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+------------------------------------
//  in       | input     | i_in_valid / o_in_stall  | req_type, addr, data_byte, range_*,
//           |           |                          | key_code, modifiers, max_chars
//  out      | output    | o_out_valid / i_out_stall| out_char, char_valid, last
//  cfg      | input     | i_cfg_valid / o_cfg_ready| cfg_index, cfg_data
//
// Load transactions leave the sequencer idle. A translate walks the range table one slot
// per cycle, then uses the single map read port and one shared address adder: a trap
// entry reads the modifier column, then the base column on a zero; a string reads its
// two-byte offset, then its characters. Output is a single register; a stalled result
// holds the sequencer in place. Reset (synchronous, active low) clears the sequencer,
// output valid and the configuration; map bytes and descriptors are undefined until loaded.
`default_nettype none

module keycode_to_char_translator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [11:0] i_addr,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [7:0]  i_range_low,
    input  wire logic [7:0]  i_range_high,
    input  wire logic [1:0]  i_range_kind,
    input  wire logic [11:0] i_range_base,
    input  wire logic [7:0]  i_key_code,
    input  wire logic [2:0]  i_modifiers,
    input  wire logic [4:0]  i_max_chars,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [7:0]  o_out_char,
    output logic             o_char_valid,
    output logic             o_last,
    // configuration
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [3:0]  i_cfg_data
);

    import kctc_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_SEARCH   = 11'b000_0000_0010,
        S_K0_ISSUE = 11'b000_0000_0100,
        S_K0_D1    = 11'b000_0000_1000,
        S_K0_D2    = 11'b000_0001_0000,
        S_K3_SLOT  = 11'b000_0010_0000,
        S_K3_LO    = 11'b000_0100_0000,
        S_K3_HI    = 11'b000_1000_0000,
        S_K3_FETCH = 11'b001_0000_0000,
        S_K3_CHK   = 11'b010_0000_0000,
        S_EMIT     = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic       r_map_valid;
    logic [3:0] r_range_count;

    // per-translate working registers
    logic [RANGE_CW-1:0] r_idx, n_idx;
    logic [RANGE_CW-1:0] r_cnt, n_cnt;
    logic [7:0]          r_key, n_key;
    logic [2:0]          r_mods, n_mods;
    logic [CHAR_CW-1:0]  r_maxc, n_maxc;
    logic [CHAR_CW-1:0]  r_n, n_n;
    t_maddr              r_ptr, n_ptr;
    logic [7:0]          r_lo, n_lo;
    logic [7:0]          r_pend, n_pend;
    logic                r_pend_cv, n_pend_cv;
    logic                r_pend_v, n_pend_v;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_cv;
    logic       r_out_last;

    // range table, one read slot chosen by the search index
    t_range r_ranges [MAX_RANGES];

    logic   in_acc;
    logic   out_free;
    logic   emit;
    logic [7:0] e_char;
    logic   e_cv;
    logic   e_last;

    // shared address adder
    t_maddr add_a;
    t_maddr add_b;
    t_maddr add_sum;

    logic       mem_re;
    logic       mem_we;
    logic [7:0] mem_rdata;

    t_range     cur;
    logic       cur_hit;
    logic [7:0] rel;
    logic [CHAR_CW-1:0] maxc_sat;
    logic [RANGE_CW-1:0] cnt_sat;
    logic [CHAR_CW-1:0]  n_inc;
    logic [7:0] ch_masked;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign add_sum = add_a + add_b;

    // current descriptor and key match
    assign cur     = r_ranges[r_idx[RANGE_AW-1:0]];
    assign cur_hit = (r_key >= cur.low) && (r_key <= cur.high);
    assign rel     = r_key - cur.low;

    // request limits, saturated
    assign maxc_sat = (32'(i_max_chars) > MAX_CHARS) ? CHAR_CW'(MAX_CHARS)
                                                     : CHAR_CW'(i_max_chars);
    assign cnt_sat  = (32'(r_range_count) > MAX_RANGES) ? RANGE_CW'(MAX_RANGES)
                                                        : RANGE_CW'(r_range_count);
    assign n_inc    = r_n + CHAR_CW'(1);

    // control mask on the trap character
    assign ch_masked = r_mods[2] ? (mem_rdata & CTRL_MASK) : mem_rdata;

    assign mem_we = in_acc && (i_req_type == REQ_WR_BYTE);

    kctc_ram #(
        .WIDTH (8),
        .DEPTH (MAP_BYTES)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (fit_addr({4'd0, i_addr})),
        .i_wdata (i_data_byte),
        .i_re    (mem_re),
        .i_raddr (add_sum),
        .o_rdata (mem_rdata)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_key     = r_key;
        n_mods    = r_mods;
        n_maxc    = r_maxc;
        n_n       = r_n;
        n_ptr     = r_ptr;
        n_lo      = r_lo;
        n_pend    = r_pend;
        n_pend_cv = r_pend_cv;
        n_pend_v  = r_pend_v;
        emit      = 1'b0;
        e_char    = 8'd0;
        e_cv      = 1'b0;
        e_last    = 1'b1;
        mem_re    = 1'b0;
        add_a     = r_ptr;
        add_b     = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_req_type == REQ_TRANSLATE)) begin
                    n_key    = i_key_code;
                    n_mods   = i_modifiers;
                    n_maxc   = maxc_sat;
                    n_cnt    = cnt_sat;
                    n_idx    = '0;
                    n_pend_v = 1'b0;
                    if (!r_map_valid || (maxc_sat == '0)) begin
                        n_pend    = 8'd0;
                        n_pend_cv = 1'b0;
                        n_state   = S_EMIT;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end

            // one slot per cycle; entry address formed on the adder
            S_SEARCH: begin
                add_a = fit_addr({4'd0, cur.base});
                if (r_idx == r_cnt) begin
                    n_pend    = 8'd0;
                    n_pend_cv = 1'b0;
                    n_state   = S_EMIT;
                end else if (cur_hit) begin
                    if (cur.kind == KIND_TRAP) begin
                        add_b   = fit_addr({6'd0, rel, 2'b00});
                        n_ptr   = add_sum;
                        n_state = S_K0_ISSUE;
                    end else if (cur.kind == KIND_STRING) begin
                        add_b   = fit_addr({7'd0, rel, 1'b0});
                        n_ptr   = add_sum;
                        n_state = S_K3_SLOT;
                    end else begin
                        n_pend    = 8'd0;
                        n_pend_cv = 1'b0;
                        n_state   = S_EMIT;
                    end
                end else begin
                    n_idx = r_idx + RANGE_CW'(1);
                end
            end

            // trap table: modifier column first
            S_K0_ISSUE: begin
                add_b   = fit_addr({14'd0, r_mods[1:0]});
                mem_re  = 1'b1;
                n_state = S_K0_D1;
            end

            S_K0_D1: begin
                if (mem_rdata != 8'd0) begin
                    n_pend    = ch_masked;
                    n_pend_cv = 1'b1;
                    n_state   = S_EMIT;
                end else begin
                    // fall back to the base column
                    mem_re  = 1'b1;
                    n_state = S_K0_D2;
                end
            end

            S_K0_D2: begin
                n_pend    = ch_masked;
                n_pend_cv = 1'b1;
                n_state   = S_EMIT;
            end

            // string offset, little endian
            S_K3_SLOT: begin
                mem_re  = 1'b1;
                n_state = S_K3_LO;
            end

            S_K3_LO: begin
                n_lo    = mem_rdata;
                add_b   = fit_addr(16'd1);
                mem_re  = 1'b1;
                n_state = S_K3_HI;
            end

            S_K3_HI: begin
                n_ptr   = fit_addr({mem_rdata, r_lo});
                n_n     = '0;
                n_state = S_K3_FETCH;
            end

            S_K3_FETCH: begin
                add_b   = fit_addr(16'(r_n));
                mem_re  = 1'b1;
                n_state = S_K3_CHK;
            end

            // previous char goes out once the next one is known
            S_K3_CHK: begin
                if (r_pend_v || (mem_rdata == 8'd0)) begin
                    if (out_free) begin
                        emit   = 1'b1;
                        e_char = r_pend_v ? r_pend : 8'd0;
                        e_cv   = r_pend_v;
                        e_last = (mem_rdata == 8'd0);
                    end
                end
                if (out_free || (!r_pend_v && (mem_rdata != 8'd0))) begin
                    if (mem_rdata == 8'd0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pend    = mem_rdata;
                        n_pend_cv = 1'b1;
                        n_pend_v  = 1'b1;
                        n_n       = n_inc;
                        n_state   = (n_inc == r_maxc) ? S_EMIT : S_K3_FETCH;
                    end
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_char  = r_pend;
                    e_cv    = r_pend_cv;
                    e_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_map_valid   <= 1'b0;
            r_range_count <= 4'd0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MAP_VALID:   r_map_valid   <= i_cfg_data[0];
                    CFG_RANGE_COUNT: r_range_count <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_cnt     <= n_cnt;
        r_key     <= n_key;
        r_mods    <= n_mods;
        r_maxc    <= n_maxc;
        r_n       <= n_n;
        r_ptr     <= n_ptr;
        r_lo      <= n_lo;
        r_pend    <= n_pend;
        r_pend_cv <= n_pend_cv;
        r_pend_v  <= n_pend_v;
        if (emit) begin
            r_out_char <= e_char;
            r_out_cv   <= e_cv;
            r_out_last <= e_last;
        end
    end

    // descriptor load, slots beyond the table dropped
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_req_type == REQ_WR_RANGE) && (32'(i_addr) < MAX_RANGES)) begin
            r_ranges[i_addr[RANGE_AW-1:0]] <= '{low:  i_range_low,
                                                high: i_range_high,
                                                kind: i_range_kind,
                                                base: i_range_base};
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_char_valid = r_out_cv;
    assign o_last       = r_out_last;

`ifndef ASSERT_OFF
    // after a load the input side is free again in the next cycle
    a_load_single_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_req_type != REQ_TRANSLATE) |=> !o_in_stall)
        else $error("load transaction held the input channel");

    // an empty result is always the last one and carries no character
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_char_valid |-> o_last && (o_out_char == 8'd0))
        else $error("empty result not marked last");

    // string walk never passes the character limit
    a_char_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_K3_FETCH) || (r_state == S_K3_CHK) |-> (r_n < r_maxc))
        else $error("string walk beyond character limit");

    // a translate with the map invalid goes straight to the final result
    a_invalid_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_req_type == REQ_TRANSLATE) && !r_map_valid |=> (r_state == S_EMIT))
        else $error("invalid map did not yield an immediate result");
`endif

endmodule

`default_nettype wire
